// ===== hdl/osrq_pkg.sv =====
// osrq_pkg: shared constants and codes of the overwriting string ring queue
// holds command and status codes, field widths and counter limits
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package osrq_pkg;

    // default ring size in bytes
    localparam int CAPACITY_DEFAULT = 64;

    // field widths
    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 12;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 6;
    localparam int TOTAL_W = 32;

    // a get streams at most this many result transactions
    localparam int MAX_RUN = 64;
    localparam int RUN_W   = $clog2(MAX_RUN);

    // saturation limits
    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(63);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_GET   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TOO_LONG = 2'd1,
        STATUS_EMPTY    = 2'd2,
        STATUS_NO_POP   = 2'd3
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/overwriting_string_ring_queue_unit.sv =====
// overwriting_string_ring_queue_unit: ring of NUL-terminated strings with overwrite
// depends on osrq_pkg and osrq_ram (the byte ring)
//
// Usage: commands enter on the s_ channel (valid/ready), results leave on the
// m_ channel (valid/ready). Push, pop and clear give one result transaction,
// get gives one per byte of the head string including its terminator, at most
// 64, with m_last_of_run on the final one.
// The ring sits in a RAM with a registered read, and every command is worked
// through by one sequencer, one command at a time. A plain push reads its
// target byte, writes it and then loads its result into the output register;
// a push that lands on a stored string walks the ring to erase it (one cycle
// a byte) and then scans for the next head (one cycle a byte). Pop costs the
// same erase and scan walks.
// Get yields one byte a cycle while the output register is free.
// A string abandoned for running too long is zeroed one byte a cycle.
// Clear zeroes every ring byte in turn.
// Reset: the queue counters and pointers clear at once, then a clearing pass
// writes zero to every ring byte; s_ready is low during it.
// Stall: a finished result waits in the output register while the sequencer
// takes the next command; the sequencer waits whenever it has a new result
// and the output register is still full.
`timescale 1ns / 1ps
`default_nettype none

module overwriting_string_ring_queue_unit #(
    parameter int CAPACITY = osrq_pkg::CAPACITY_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [osrq_pkg::CMD_W-1:0]    s_command,
    input  wire logic [osrq_pkg::BYTE_W-1:0]   s_data_byte,
    input  wire logic [osrq_pkg::LEN_W-1:0]    s_string_length,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [osrq_pkg::STAT_W-1:0]   m_status,
    output logic      [osrq_pkg::BYTE_W-1:0]   m_read_byte,
    output logic                               m_last_of_run,
    output logic      [osrq_pkg::COUNT_W-1:0]  m_strings_stored,
    output logic      [osrq_pkg::TOTAL_W-1:0]  m_overwritten_total,
    output logic      [osrq_pkg::TOTAL_W-1:0]  m_popped_total
);

    import osrq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [AW-1:0]    LastIdx = AW'(CAPACITY - 1);
    localparam logic [AW:0]      CapSum  = (AW + 1)'(CAPACITY);
    localparam logic [CW-1:0]    CapCnt  = CW'(CAPACITY);
    localparam logic [LEN_W:0]   LenCap  = (LEN_W + 1)'(CAPACITY);
    localparam logic [RUN_W-1:0] RunLast = RUN_W'(MAX_RUN - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PUT_CHK,
        S_ER_CHK,
        S_SE_CHK,
        S_PUT_WR,
        S_ABANDON,
        S_GET_OUT,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PUT_FIRST,
        PUT_CHAR,
        PUT_TERM
    } put_ctx_t;

    typedef enum logic {
        RET_PUT,
        RET_POP
    } ret_t;

    // sequencer and queue state
    state_t             state_reg, state_next;
    logic               clr_cmd_reg, clr_cmd_next;
    logic [AW-1:0]      clr_idx_reg, clr_idx_next;
    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      wi_reg, wi_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [TOTAL_W-1:0] ovw_reg, ovw_next;
    logic [TOTAL_W-1:0] pop_reg, pop_next;
    logic               inprog_reg, inprog_next;
    logic               drop_reg, drop_next;
    logic [AW-1:0]      plen_reg, plen_next;
    put_ctx_t           ctx_reg, ctx_next;
    ret_t               ret_reg, ret_next;
    logic [AW-1:0]      walk_p_reg, walk_p_next;
    logic [CW-1:0]      walk_n_reg, walk_n_next;
    logic [RUN_W-1:0]   get_k_reg, get_k_next;
    status_t            status_reg, status_next;
    logic [AW-1:0]      put_p_reg, put_p_next;
    logic [BYTE_W-1:0]  put_b_reg, put_b_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]  m_status_reg, m_status_next;
    logic [BYTE_W-1:0]  m_byte_reg, m_byte_next;
    logic               m_last_reg, m_last_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;
    logic [TOTAL_W-1:0] m_ovw_reg, m_ovw_next;
    logic [TOTAL_W-1:0] m_pop_reg, m_pop_next;

    // ring port
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [BYTE_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [BYTE_W-1:0]  ram_rdata;

    logic               out_free;
    logic               out_load;
    status_t            out_status;
    logic [BYTE_W-1:0]  out_byte;
    logic               out_last;
    logic [AW:0]        pos_sum;
    logic [AW-1:0]      push_pos;
    logic               too_long;
    cmd_t               cmd;

    function automatic logic [AW-1:0] step_on(input logic [AW-1:0] i);
        step_on = (i == LastIdx) ? '0 : AW'(i + 1'b1);
    endfunction

    osrq_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CAPACITY)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign cmd      = cmd_t'(s_command);

    // position of the next byte of the string in progress
    assign pos_sum  = {1'b0, wi_reg} + {1'b0, plen_reg};
    assign push_pos = (pos_sum >= CapSum) ? AW'(pos_sum - CapSum) : pos_sum[AW-1:0];
    assign too_long = ({1'b0, s_string_length} + (LEN_W + 1)'(1)) > LenCap;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        clr_cmd_next = clr_cmd_reg;
        clr_idx_next = clr_idx_reg;
        head_next    = head_reg;
        wi_next      = wi_reg;
        count_next   = count_reg;
        ovw_next     = ovw_reg;
        pop_next     = pop_reg;
        inprog_next  = inprog_reg;
        drop_next    = drop_reg;
        plen_next    = plen_reg;
        ctx_next     = ctx_reg;
        ret_next     = ret_reg;
        walk_p_next  = walk_p_reg;
        walk_n_next  = walk_n_reg;
        get_k_next   = get_k_reg;
        status_next  = status_reg;
        put_p_next   = put_p_reg;
        put_b_next   = put_b_reg;

        ram_we    = 1'b0;
        ram_waddr = walk_p_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = walk_p_reg;

        out_load   = 1'b0;
        out_status = status_reg;
        out_byte   = '0;
        out_last   = 1'b1;

        case (state_reg)
            // zero the ring one byte a cycle
            S_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_idx_reg;
                clr_idx_next = step_on(clr_idx_reg);
                if (clr_idx_reg == LastIdx) begin
                    status_next = STATUS_OK;
                    state_next  = clr_cmd_reg ? S_EMIT : S_IDLE;
                end
            end

            // take a command and start its work
            S_IDLE: begin
                if (s_valid) begin
                    put_b_next = s_data_byte;
                    case (cmd)
                        CMD_PUSH: begin
                            if (drop_reg) begin
                                if (s_data_byte == '0) begin
                                    drop_next = 1'b0;
                                end
                                status_next = STATUS_TOO_LONG;
                                state_next  = S_EMIT;
                            end else if (!inprog_reg) begin
                                if (s_data_byte == '0) begin
                                    status_next = STATUS_EMPTY;
                                    state_next  = S_EMIT;
                                end else if (too_long) begin
                                    drop_next   = 1'b1;
                                    status_next = STATUS_TOO_LONG;
                                    state_next  = S_EMIT;
                                end else begin
                                    put_p_next = wi_reg;
                                    ctx_next   = PUT_FIRST;
                                    ram_re     = 1'b1;
                                    ram_raddr  = wi_reg;
                                    state_next = S_PUT_CHK;
                                end
                            end else if (s_data_byte == '0) begin
                                put_p_next = push_pos;
                                ctx_next   = PUT_TERM;
                                ram_re     = 1'b1;
                                ram_raddr  = push_pos;
                                state_next = S_PUT_CHK;
                            end else if (plen_reg >= LastIdx) begin
                                walk_p_next = wi_reg;
                                walk_n_next = '0;
                                state_next  = S_ABANDON;
                            end else begin
                                put_p_next = push_pos;
                                ctx_next   = PUT_CHAR;
                                ram_re     = 1'b1;
                                ram_raddr  = push_pos;
                                state_next = S_PUT_CHK;
                            end
                        end
                        CMD_POP: begin
                            if (count_reg == '0) begin
                                status_next = STATUS_NO_POP;
                                state_next  = S_EMIT;
                            end else begin
                                count_next = count_reg - 1'b1;
                                if (pop_reg != TOTAL_MAX) begin
                                    pop_next = pop_reg + 1'b1;
                                end
                                walk_p_next = head_reg;
                                walk_n_next = '0;
                                ret_next    = RET_POP;
                                ram_re      = 1'b1;
                                ram_raddr   = head_reg;
                                state_next  = S_ER_CHK;
                            end
                        end
                        CMD_GET: begin
                            if (count_reg == '0) begin
                                status_next = STATUS_OK;
                                state_next  = S_EMIT;
                            end else begin
                                walk_p_next = head_reg;
                                get_k_next  = '0;
                                ram_re      = 1'b1;
                                ram_raddr   = head_reg;
                                state_next  = S_GET_OUT;
                            end
                        end
                        CMD_CLEAR: begin
                            head_next    = '0;
                            wi_next      = '0;
                            count_next   = '0;
                            ovw_next     = '0;
                            pop_next     = '0;
                            inprog_next  = 1'b0;
                            drop_next    = 1'b0;
                            plen_next    = '0;
                            clr_cmd_next = 1'b1;
                            clr_idx_next = '0;
                            state_next   = S_CLEAR;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // target byte read: free, or an older string to overwrite
            S_PUT_CHK: begin
                if (ram_rdata == '0) begin
                    state_next = S_PUT_WR;
                end else begin
                    if (count_reg != '0) begin
                        count_next = count_reg - 1'b1;
                    end
                    if (ovw_reg != TOTAL_MAX) begin
                        ovw_next = ovw_reg + 1'b1;
                    end
                    // read data of the target stays on the ram output
                    walk_p_next = put_p_reg;
                    walk_n_next = '0;
                    ret_next    = RET_PUT;
                    state_next  = S_ER_CHK;
                end
            end

            // erase a run of non-zero bytes, read ahead while writing zero
            S_ER_CHK: begin
                if (walk_n_reg != CapCnt && ram_rdata != '0) begin
                    ram_we      = 1'b1;
                    ram_waddr   = walk_p_reg;
                    walk_p_next = step_on(walk_p_reg);
                    walk_n_next = walk_n_reg + 1'b1;
                    ram_re      = 1'b1;
                    ram_raddr   = step_on(walk_p_reg);
                end else if (count_reg == '0) begin
                    head_next   = wi_reg;
                    status_next = STATUS_OK;
                    state_next  = (ret_reg == RET_PUT) ? S_PUT_WR : S_EMIT;
                end else begin
                    // scan for the next head from the stop byte
                    walk_n_next = '0;
                    ram_re      = 1'b1;
                    ram_raddr   = walk_p_reg;
                    state_next  = S_SE_CHK;
                end
            end

            // find the first non-zero byte as the new head
            S_SE_CHK: begin
                if (walk_n_reg == CapCnt) begin
                    head_next   = wi_reg;
                    status_next = STATUS_OK;
                    state_next  = (ret_reg == RET_PUT) ? S_PUT_WR : S_EMIT;
                end else if (ram_rdata != '0) begin
                    head_next   = walk_p_reg;
                    status_next = STATUS_OK;
                    state_next  = (ret_reg == RET_PUT) ? S_PUT_WR : S_EMIT;
                end else begin
                    walk_p_next = step_on(walk_p_reg);
                    walk_n_next = walk_n_reg + 1'b1;
                    ram_re      = 1'b1;
                    ram_raddr   = step_on(walk_p_reg);
                end
            end

            // store the pushed byte and update the string in progress
            S_PUT_WR: begin
                ram_we      = 1'b1;
                ram_waddr   = put_p_reg;
                ram_wdata   = put_b_reg;
                status_next = STATUS_OK;
                state_next  = S_EMIT;
                case (ctx_reg)
                    PUT_FIRST: begin
                        inprog_next = 1'b1;
                        plen_next   = AW'(1);
                    end
                    PUT_CHAR: begin
                        plen_next = plen_reg + 1'b1;
                    end
                    PUT_TERM: begin
                        wi_next = step_on(put_p_reg);
                        if (count_reg == '0) begin
                            head_next = wi_reg;
                        end
                        if (count_reg < COUNT_MAX) begin
                            count_next = count_reg + 1'b1;
                        end
                        inprog_next = 1'b0;
                        plen_next   = '0;
                    end
                    default: begin
                        plen_next = plen_reg;
                    end
                endcase
            end

            // zero the bytes of a string that ran too long
            S_ABANDON: begin
                ram_we      = 1'b1;
                ram_waddr   = walk_p_reg;
                walk_p_next = step_on(walk_p_reg);
                walk_n_next = walk_n_reg + 1'b1;
                if ((walk_n_reg + 1'b1) == CW'(plen_reg)) begin
                    inprog_next = 1'b0;
                    plen_next   = '0;
                    drop_next   = 1'b1;
                    if (count_reg == '0) begin
                        head_next = wi_reg;
                    end
                    status_next = STATUS_TOO_LONG;
                    state_next  = S_EMIT;
                end
            end

            // stream the head string, one byte a transaction
            S_GET_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = STATUS_OK;
                    out_byte   = ram_rdata;
                    out_last   = (ram_rdata == '0) || (get_k_reg == RunLast);
                    if (out_last) begin
                        state_next = S_IDLE;
                    end else begin
                        walk_p_next = step_on(walk_p_reg);
                        get_k_next  = get_k_reg + 1'b1;
                        ram_re      = 1'b1;
                        ram_raddr   = step_on(walk_p_reg);
                    end
                end
            end

            // single result of push, pop, clear or a get on an empty queue
            S_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = status_reg;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        m_valid_next  = m_ready ? 1'b0 : m_valid_reg;
        m_status_next = m_status_reg;
        m_byte_next   = m_byte_reg;
        m_last_next   = m_last_reg;
        m_count_next  = m_count_reg;
        m_ovw_next    = m_ovw_reg;
        m_pop_next    = m_pop_reg;
        if (out_load) begin
            m_valid_next  = 1'b1;
            m_status_next = out_status;
            m_byte_next   = out_byte;
            m_last_next   = out_last;
            m_count_next  = count_reg;
            m_ovw_next    = ovw_reg;
            m_pop_next    = pop_reg;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cmd_reg <= 1'b0;
            clr_idx_reg <= '0;
            head_reg    <= '0;
            wi_reg      <= '0;
            count_reg   <= '0;
            ovw_reg     <= '0;
            pop_reg     <= '0;
            inprog_reg  <= 1'b0;
            drop_reg    <= 1'b0;
            plen_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cmd_reg <= clr_cmd_next;
            clr_idx_reg <= clr_idx_next;
            head_reg    <= head_next;
            wi_reg      <= wi_next;
            count_reg   <= count_next;
            ovw_reg     <= ovw_next;
            pop_reg     <= pop_next;
            inprog_reg  <= inprog_next;
            drop_reg    <= drop_next;
            plen_reg    <= plen_next;
            m_valid_reg <= m_valid_next;
        end
        ctx_reg      <= ctx_next;
        ret_reg      <= ret_next;
        walk_p_reg   <= walk_p_next;
        walk_n_reg   <= walk_n_next;
        get_k_reg    <= get_k_next;
        status_reg   <= status_next;
        put_p_reg    <= put_p_next;
        put_b_reg    <= put_b_next;
        m_status_reg <= m_status_next;
        m_byte_reg   <= m_byte_next;
        m_last_reg   <= m_last_next;
        m_count_reg  <= m_count_next;
        m_ovw_reg    <= m_ovw_next;
        m_pop_reg    <= m_pop_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = m_status_reg;
    assign m_read_byte         = m_byte_reg;
    assign m_last_of_run       = m_last_reg;
    assign m_strings_stored    = m_count_reg;
    assign m_overwritten_total = m_ovw_reg;
    assign m_popped_total      = m_pop_reg;

endmodule

`default_nettype wire

// ===== hdl/osrq_ram.sv =====
// osrq_ram: generic simple dual-port ram, one write and one registered read
// depth and width set by parameters
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module osrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port; read data holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sim/osrq_checker.sv =====
`timescale 1ns / 1ps
// osrq_checker: watches both channels of the string ring queue, works out every
// reply transaction from its own copy of the ring and compares, field by field
// depends on osrq_pkg

module osrq_checker #(
    parameter int CAPACITY = osrq_pkg::CAPACITY_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [osrq_pkg::CMD_W-1:0]    s_command,
    input  logic [osrq_pkg::BYTE_W-1:0]   s_data_byte,
    input  logic [osrq_pkg::LEN_W-1:0]    s_string_length,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [osrq_pkg::STAT_W-1:0]   m_status,
    input  logic [osrq_pkg::BYTE_W-1:0]   m_read_byte,
    input  logic                          m_last_of_run,
    input  logic [osrq_pkg::COUNT_W-1:0]  m_strings_stored,
    input  logic [osrq_pkg::TOTAL_W-1:0]  m_overwritten_total,
    input  logic [osrq_pkg::TOTAL_W-1:0]  m_popped_total,
    output int                            mismatches,
    output int                            replies_due
);

    import osrq_pkg::*;

    typedef struct {
        status_t             status;
        logic [BYTE_W-1:0]   read_byte;
        logic                last;
        logic [COUNT_W-1:0]  stored;
        logic [TOTAL_W-1:0]  overwritten;
        logic [TOTAL_W-1:0]  popped;
    } reply_t;

    // replies still owed by the block, oldest first
    reply_t pending_replies[$];
    reply_t want;

    // own copy of the queue state
    logic [BYTE_W-1:0]  ring [0:CAPACITY-1];
    int                 head_pos;
    int                 write_pos;
    int                 string_total;
    int                 chars_so_far;
    logic [TOTAL_W-1:0] overwrite_count;
    logic [TOTAL_W-1:0] pop_count;
    bit                 in_string;
    bit                 dropping;

    function automatic int next_pos(input int p);
        return (p + 1 >= CAPACITY) ? 0 : p + 1;
    endfunction

    function automatic void wipe_state();
        for (int i = 0; i < CAPACITY; i++) ring[i] = '0;
        head_pos        = 0;
        write_pos       = 0;
        string_total    = 0;
        chars_so_far    = 0;
        overwrite_count = '0;
        pop_count       = '0;
        in_string       = 1'b0;
        dropping        = 1'b0;
    endfunction

    // zero a run of non-zero bytes, return the position that stopped it
    function automatic int erase_from(input int start);
        int p;
        int n;
        p = start;
        n = 0;
        while (n < CAPACITY && ring[p] != '0) begin
            ring[p] = '0;
            p = next_pos(p);
            n++;
        end
        return p;
    endfunction

    // head goes to the next stored byte, or to the write pointer when empty
    function automatic void find_head(input int from);
        int p;
        bit found;
        p = from;
        found = 1'b0;
        if (string_total != 0) begin
            for (int n = 0; n < CAPACITY && !found; n++) begin
                if (ring[p] != '0) begin
                    head_pos = p;
                    found = 1'b1;
                end else begin
                    p = next_pos(p);
                end
            end
        end
        if (!found) head_pos = write_pos;
    endfunction

    // a write onto a stored byte erases the oldest string
    function automatic void write_byte(input int p, input logic [BYTE_W-1:0] b);
        int stop;
        if (ring[p] != '0) begin
            stop = erase_from(p);
            if (string_total > 0) string_total--;
            if (overwrite_count != TOTAL_MAX) overwrite_count++;
            find_head(stop);
        end
        ring[p] = b;
    endfunction

    function automatic status_t push_status(input logic [BYTE_W-1:0] b,
                                            input logic [LEN_W-1:0] len);
        status_t st;
        int p;
        int start;
        st = STATUS_OK;
        if (dropping) begin
            // rest of a refused or abandoned string, up to its terminator
            if (b == '0) dropping = 1'b0;
            st = STATUS_TOO_LONG;
        end else if (!in_string) begin
            if (b == '0) begin
                st = STATUS_EMPTY;
            end else if (int'(len) + 1 > CAPACITY) begin
                dropping = 1'b1;
                st = STATUS_TOO_LONG;
            end else begin
                write_byte(write_pos, b);
                in_string = 1'b1;
                chars_so_far = 1;
            end
        end else begin
            p = (write_pos + chars_so_far) % CAPACITY;
            if (b == '0) begin
                // terminator makes it a stored string
                start = write_pos;
                write_byte(p, '0);
                write_pos = next_pos(p);
                if (string_total == 0) head_pos = start;
                if (string_total < int'(COUNT_MAX)) string_total++;
                in_string = 1'b0;
                chars_so_far = 0;
            end else if (chars_so_far >= CAPACITY - 1) begin
                // longer than the ring allows: zero what was written, drop the rest
                p = write_pos;
                for (int n = 0; n < chars_so_far; n++) begin
                    ring[p] = '0;
                    p = next_pos(p);
                end
                in_string = 1'b0;
                chars_so_far = 0;
                dropping = 1'b1;
                if (string_total == 0) head_pos = write_pos;
                st = STATUS_TOO_LONG;
            end else begin
                write_byte(p, b);
                chars_so_far++;
            end
        end
        return st;
    endfunction

    function automatic void add_reply(input status_t st, input logic [BYTE_W-1:0] b,
                                      input logic last);
        reply_t r;
        r.status      = st;
        r.read_byte   = b;
        r.last        = last;
        r.stored      = COUNT_W'(string_total);
        r.overwritten = overwrite_count;
        r.popped      = pop_count;
        pending_replies.push_back(r);
    endfunction

    function automatic void run_queue_command(input cmd_t cmd,
                                              input logic [BYTE_W-1:0] b,
                                              input logic [LEN_W-1:0] len);
        int p;
        bit done;
        logic [BYTE_W-1:0] v;
        case (cmd)
            CMD_PUSH: begin
                add_reply(push_status(b, len), '0, 1'b1);
            end
            CMD_POP: begin
                if (string_total == 0) begin
                    add_reply(STATUS_NO_POP, '0, 1'b1);
                end else begin
                    string_total--;
                    if (pop_count != TOTAL_MAX) pop_count++;
                    find_head(erase_from(head_pos));
                    add_reply(STATUS_OK, '0, 1'b1);
                end
            end
            CMD_GET: begin
                if (string_total == 0) begin
                    add_reply(STATUS_OK, '0, 1'b1);
                end else begin
                    // head string with its terminator, cut at MAX_RUN bytes
                    p = head_pos;
                    done = 1'b0;
                    for (int k = 0; k < MAX_RUN && !done; k++) begin
                        v = ring[p];
                        done = (v == '0) || (k == MAX_RUN - 1);
                        add_reply(STATUS_OK, v, done);
                        p = next_pos(p);
                    end
                end
            end
            default: begin
                wipe_state();
                add_reply(STATUS_OK, '0, 1'b1);
            end
        endcase
    endfunction

    // predict on accepted commands, compare accepted replies
    always @(posedge aclk) begin
        if (!aresetn) begin
            wipe_state();
            pending_replies.delete();
        end else begin
            if (s_valid && s_ready)
                run_queue_command(cmd_t'(s_command), s_data_byte, s_string_length);
            if (m_valid && m_ready) begin
                if (pending_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected reply: status %0d byte %02h last %0b",
                                 $realtime, m_status, m_read_byte, m_last_of_run);
                end else begin
                    want = pending_replies.pop_front();
                    if (want.status      !== m_status      ||
                        want.read_byte   !== m_read_byte   ||
                        want.last        !== m_last_of_run ||
                        want.stored      !== m_strings_stored ||
                        want.overwritten !== m_overwritten_total ||
                        want.popped      !== m_popped_total) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("[%0t] reply mismatch", $realtime);
                            $display("  exp st %0d byte %02h last %0b cnt %0d ovw %0d pop %0d",
                                     want.status, want.read_byte, want.last,
                                     want.stored, want.overwritten, want.popped);
                            $display("  got st %0d byte %02h last %0b cnt %0d ovw %0d pop %0d",
                                     m_status, m_read_byte, m_last_of_run,
                                     m_strings_stored, m_overwritten_total,
                                     m_popped_total);
                        end
                    end
                end
            end
        end
        replies_due = pending_replies.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for overwriting_string_ring_queue_unit
// depends on osrq_pkg, the block itself and osrq_checker

module tb_top;

    import osrq_pkg::*;

    localparam int CAPACITY      = CAPACITY_DEFAULT;
    localparam int ITEM_TARGET   = 350;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 2 * CAPACITY + 16;
    localparam int MAX_GAP       = 30;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [CMD_W-1:0]    s_command;
    logic [BYTE_W-1:0]   s_data_byte;
    logic [LEN_W-1:0]    s_string_length;
    logic                m_valid;
    logic                m_ready;
    logic [STAT_W-1:0]   m_status;
    logic [BYTE_W-1:0]   m_read_byte;
    logic                m_last_of_run;
    logic [COUNT_W-1:0]  m_strings_stored;
    logic [TOTAL_W-1:0]  m_overwritten_total;
    logic [TOTAL_W-1:0]  m_popped_total;

    int mismatches;
    int replies_due;
    int send_idle_pct;
    int stall_pct;
    int items_sent;
    int cycle_count;

    overwriting_string_ring_queue_unit #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_data_byte(s_data_byte),
        .s_string_length(s_string_length),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_read_byte(m_read_byte),
        .m_last_of_run(m_last_of_run),
        .m_strings_stored(m_strings_stored),
        .m_overwritten_total(m_overwritten_total),
        .m_popped_total(m_popped_total)
    );

    osrq_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command(s_command),
        .s_data_byte(s_data_byte),
        .s_string_length(s_string_length),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_status(m_status),
        .m_read_byte(m_read_byte),
        .m_last_of_run(m_last_of_run),
        .m_strings_stored(m_strings_stored),
        .m_overwritten_total(m_overwritten_total),
        .m_popped_total(m_popped_total),
        .mismatches(mismatches),
        .replies_due(replies_due)
    );

    // 4 ns clock
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // idling follows the share of the run already sent
    task automatic pick_idle_mode();
        case ((items_sent * 4) / ITEM_TARGET)
            0: begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            1: begin
                send_idle_pct = 57;
                stall_pct = 0;
            end
            2: begin
                send_idle_pct = 0;
                stall_pct = 57;
            end
            default: begin
                send_idle_pct = 27;
                stall_pct = 27;
            end
        endcase
    endtask

    // one command transaction; entered and left at a falling edge
    task automatic send_item(input cmd_t cmd, input logic [BYTE_W-1:0] b,
                             input logic [LEN_W-1:0] len);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_command       <= cmd;
        s_data_byte     <= b;
        s_string_length <= len;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    // pop or get with random don't-care fields
    task automatic send_query(input bit do_get);
        if (do_get)
            send_item(CMD_GET, BYTE_W'($urandom), LEN_W'($urandom));
        else
            send_item(CMD_POP, BYTE_W'($urandom), LEN_W'($urandom));
    endtask

    // a string of random non-zero characters and its terminator
    task automatic send_string(input int chars, input int announced);
        for (int i = 0; i < chars; i++) begin
            send_item(CMD_PUSH, BYTE_W'($urandom_range(255, 1)),
                      (i == 0) ? LEN_W'(announced) : LEN_W'($urandom_range(4095)));
            // now and then a query lands in the middle of a string
            if ($urandom_range(99) < 3) send_query(1'($urandom_range(1)));
        end
        send_item(CMD_PUSH, '0, LEN_W'($urandom_range(4095)));
    endtask

    initial begin : stimulus
        int pick;
        int chars;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_command       = CMD_PUSH;
        s_data_byte     = '0;
        s_string_length = '0;
        m_ready         = 1'b0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        items_sent      = 0;
        cycle_count     = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty queue, refusals, field extremes, in-progress cases
        send_item(CMD_GET,  8'h00, 12'd0);
        send_item(CMD_POP,  8'hFF, 12'hFFF);
        send_item(CMD_PUSH, 8'h00, 12'd5);      // empty string
        send_item(CMD_PUSH, 8'hFF, 12'hFFF);    // far too long
        send_item(CMD_PUSH, 8'hAA, 12'd1);
        send_item(CMD_PUSH, 8'h00, 12'd0);
        send_item(CMD_PUSH, 8'h41, 12'd64);     // one past the limit
        send_item(CMD_PUSH, 8'h00, 12'd0);
        send_item(CMD_PUSH, 8'h01, 12'd1);
        send_item(CMD_PUSH, 8'h00, 12'd0);
        send_item(CMD_PUSH, 8'h80, 12'd63);     // longest allowed length
        send_item(CMD_PUSH, 8'hFF, 12'd0);
        send_item(CMD_PUSH, 8'h00, 12'd0);
        send_item(CMD_GET,  8'h00, 12'd0);
        send_item(CMD_POP,  8'h00, 12'd0);
        send_item(CMD_GET,  8'h00, 12'd0);
        send_item(CMD_PUSH, 8'h7F, 12'd2);      // string left in progress
        send_item(CMD_GET,  8'h00, 12'd0);
        send_item(CMD_POP,  8'h00, 12'd0);      // queue emptied
        send_item(CMD_POP,  8'h00, 12'd0);
        send_item(CMD_PUSH, 8'h55, 12'd0);
        send_item(CMD_CLEAR, 8'hFF, 12'hFFF);   // discards the partial string
        send_item(CMD_PUSH, 8'h00, 12'd0);

        // random: mostly whole strings, then queries and noise
        while (items_sent < ITEM_TARGET) begin
            pick_idle_mode();
            pick = $urandom_range(99);
            if (pick < 40) begin
                chars = $urandom_range(10, 1);
                send_string(chars, ($urandom_range(9) == 0) ? $urandom_range(63) : chars);
            end else if (pick < 45) begin
                // long string wraps over everything, then a full-length read
                send_string($urandom_range(63, 40), 63);
                send_query(1'b1);
            end else if (pick < 48) begin
                // runs past the ring size
                send_string($urandom_range(68, 64), $urandom_range(63, 1));
            end else if (pick < 53) begin
                send_string($urandom_range(8, 1), $urandom_range(4095, 64));
            end else if (pick < 68) begin
                send_query(1'b1);
            end else if (pick < 80) begin
                send_query(1'b0);
            end else if (pick < 82) begin
                send_item(CMD_CLEAR, BYTE_W'($urandom), LEN_W'($urandom));
            end else begin
                send_item(CMD_PUSH,
                          ($urandom_range(4) == 0) ? '0 : BYTE_W'($urandom),
                          LEN_W'($urandom));
            end
        end
        s_valid <= 1'b0;

        // drain, then let the block settle
        while (replies_due != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0 && replies_due == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
